/* rtl/core/lz_hash_block_decompressor_assert.svh */
// Assertion macros for the LZ hash block decompressor.
// Used by the top level only; compiled out when SYNTH is defined.
`ifndef LZ_HASH_BLOCK_DECOMPRESSOR_ASSERT_SVH
`define LZ_HASH_BLOCK_DECOMPRESSOR_ASSERT_SVH
`ifndef SYNTH
`define LZHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LZHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LZHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LZHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/lzhd_pkg.sv */
// Shared types and constants for the LZ hash block decompressor.
// No dependencies.
package lzhd_pkg;
    localparam int HIST_BITS_DEF = 16;
    localparam int HASH_BITS     = 16;
    localparam int POS_W         = 17;
    localparam int CAP_W         = 17;
    localparam logic [31:0] HASH_MUL = 32'd1527631329;
    localparam logic [CAP_W-1:0] CAP_RESET = 17'd65536;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW = 3'd1;
    localparam logic [2:0] ERR_TRUNC    = 3'd2;
    localparam logic [2:0] ERR_BADREF   = 3'd3;
    localparam logic [2:0] ERR_BUSY     = 3'd4;

    typedef struct packed {
        logic [POS_W-1:0] produced_count;
        logic [2:0]       error_code;
        logic             busy_res;
        logic             out_last;
        logic             out_valid;
        logic [7:0]       out_byte;
    } t_result;
endpackage

/* rtl/core/lzhd_ram.sv */
// Simple dual-port RAM, one write and one registered read per cycle.
// A same-cycle write to the read address is forwarded. No dependencies.
module lzhd_ram #(
    parameter int AW = 16,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_q;
    logic [DW-1:0] r_wd;
    logic          r_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q  <= mem[i_raddr];
        r_wd <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_hit ? r_wd : r_q;
endmodule

/* rtl/core/lzhd_tab.sv */
// Position table: RAM plus the clearing sweep that runs after reset.
// Depends on lzhd_pkg and lzhd_ram.
module lzhd_tab (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [lzhd_pkg::HASH_BITS-1:0] i_waddr,
    input  logic [15:0]                   i_wdata,
    input  logic [lzhd_pkg::HASH_BITS-1:0] i_raddr,
    output logic [15:0]                   o_rdata,
    output logic                          o_ready
);
    logic                          r_clr;
    logic [lzhd_pkg::HASH_BITS-1:0] r_clr_addr;
    logic                          w_we;
    logic [lzhd_pkg::HASH_BITS-1:0] w_waddr;
    logic [15:0]                   w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr <= 1'b0;
            end
        end
    end

    assign w_we    = r_clr || i_we;
    assign w_waddr = r_clr ? r_clr_addr : i_waddr;
    assign w_wdata = r_clr ? 16'h0000 : i_wdata;
    assign o_ready = !r_clr;

    lzhd_ram #(.AW(lzhd_pkg::HASH_BITS), .DW(16)) u_ram (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(i_raddr),
        .o_rdata(o_rdata)
    );
endmodule

/* rtl/core/lzhd_parser.sv */
// Token parser and copy engine: per-beat state update, hash, memory requests.
// Depends on lzhd_pkg; memories sit outside.
module lzhd_parser #(
    parameter int HIST_BITS = lzhd_pkg::HIST_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_room,
    output logic                           o_ready,
    input  logic                           i_op,
    input  logic [7:0]                     i_byte,
    input  logic                           i_last,
    input  logic [lzhd_pkg::CAP_W-1:0]     i_capacity,
    input  logic [7:0]                     i_hist_q,
    input  logic [15:0]                    i_tab_q,
    output logic                           o_hist_we,
    output logic [HIST_BITS-1:0]           o_hist_waddr,
    output logic [7:0]                     o_hist_wdata,
    output logic [HIST_BITS-1:0]           o_hist_raddr,
    output logic                           o_tab_we,
    output logic [lzhd_pkg::HASH_BITS-1:0] o_tab_waddr,
    output logic [15:0]                    o_tab_wdata,
    output logic [lzhd_pkg::HASH_BITS-1:0] o_tab_raddr,
    output logic                           o_res_valid,
    output lzhd_pkg::t_result              o_res,
    output logic                           o_wait
);
    localparam logic [3:0] PH_HDR      = 4'd0;
    localparam logic [3:0] PH_HASH_LO  = 4'd1;
    localparam logic [3:0] PH_HASH_HI  = 4'd2;
    localparam logic [3:0] PH_DIST     = 4'd3;
    localparam logic [3:0] PH_LIT_TAG  = 4'd4;
    localparam logic [3:0] PH_LIT_DATA = 4'd5;
    localparam logic [3:0] PH_SEQ_TAG  = 4'd6;
    localparam logic [3:0] PH_SEQ_DATA = 4'd7;
    localparam logic [3:0] PH_LITERALS = 4'd8;
    localparam logic [3:0] PH_MATCH    = 4'd9;
    localparam logic [3:0] PH_HALT     = 4'd10;
    localparam int PW = lzhd_pkg::POS_W;

    logic [3:0]    r_phase, n_phase;
    logic [7:0]    r_hdr, n_hdr;
    logic [32:0]   r_acc, n_acc;
    logic [33:0]   r_lit, n_lit;
    logic [33:0]   r_match, n_match;
    logic [15:0]   r_href, n_href;
    logic [8:0]    r_dist, n_dist;
    logic [PW-1:0] r_src, n_src;
    logic [2:0]    r_err, n_err;
    logic [PW-1:0] r_pos, n_pos;
    logic [31:0]   r_hprod, n_hprod;   // last four bytes times the hash multiplier
    logic [2:0]    r_left, n_left;
    logic [1:0]    r_sh, n_sh;
    logic          r_endp, n_endp;
    logic          r_wait;

    logic          w_hold, w_go;
    logic          v_put, v_counts, v_litext, v_extfin, v_forlit, v_fin, v_start, v_end;
    logic          v_byte_step;
    logic [7:0]    v_pb;
    logic [31:0]   v_bm;
    logic [31:0]   v_full;
    logic [15:0]   v_key, v_tv;
    logic [34:0]   v_sum;
    logic [PW:0]   v_hsrc;

    // A hashed token whose match starts right after its index needs the table
    // entry of an index that is still on the input: read it, then take the beat.
    assign w_hold = (r_phase == PH_HASH_HI) && !i_op && (r_hdr[6:4] == 3'd0)
                  && (r_hdr[3:0] != 4'hf) && ({i_byte, r_href[7:0]} != 16'hffff)
                  && !r_wait;
    assign o_ready = i_room && !w_hold;
    assign w_go    = i_valid && o_ready;
    assign o_wait  = r_wait;

    always_comb begin
        n_phase = r_phase; n_hdr = r_hdr; n_acc = r_acc; n_lit = r_lit;
        n_match = r_match; n_href = r_href; n_dist = r_dist; n_src = r_src;
        n_err = r_err; n_pos = r_pos; n_hprod = r_hprod; n_left = r_left;
        n_sh = r_sh; n_endp = r_endp;
        v_put = 1'b0; v_counts = 1'b0; v_litext = 1'b0; v_extfin = 1'b0;
        v_forlit = 1'b0; v_fin = 1'b0; v_start = 1'b0; v_end = 1'b0;
        v_byte_step = 1'b0; v_pb = 8'h00;
        v_bm = '0; v_full = '0; v_key = '0; v_tv = '0; v_sum = '0; v_hsrc = '0;
        o_res_valid = 1'b0;
        o_res = '0;

        if (w_go) begin
            if (i_op) begin
                if (r_phase == PH_MATCH) begin
                    o_res_valid = 1'b1;
                    v_put = 1'b1;
                    v_pb = i_hist_q;
                    n_src = r_src + 1'b1;
                    n_match = r_match - 1'b1;
                    if (r_match == 34'd1) begin
                        n_phase = PH_HDR;
                        if (r_endp) begin
                            o_res.out_last = 1'b1;
                            v_end = 1'b1;
                        end
                    end
                end
            end else if (r_phase == PH_MATCH) begin
                o_res_valid = 1'b1;
                o_res.error_code = lzhd_pkg::ERR_BUSY;
            end else if (r_phase == PH_HALT) begin
                o_res_valid = 1'b1;
                o_res.error_code = r_err;
                if (i_last) begin
                    o_res.out_last = 1'b1;
                    v_end = 1'b1;
                end
            end else begin
                o_res_valid = 1'b1;
                v_byte_step = 1'b1;
                v_forlit = (r_phase == PH_LIT_TAG) || (r_phase == PH_LIT_DATA);
                unique case (r_phase)
                    PH_HDR: begin
                        n_hdr = i_byte;
                        n_phase = i_byte[7] ? PH_HASH_LO : PH_DIST;
                    end
                    PH_HASH_LO: begin
                        n_href = {8'h00, i_byte};
                        n_phase = PH_HASH_HI;
                    end
                    PH_HASH_HI: begin
                        n_href = {i_byte, r_href[7:0]};
                        v_counts = 1'b1;
                        if ({i_byte, r_href[7:0]} == 16'hffff) begin
                            n_lit = {27'd0, r_hdr[6:0]};
                            n_match = '0;
                            v_litext = (r_hdr[6:0] == 7'h7f);
                        end else begin
                            n_lit = {31'd0, r_hdr[6:4]};
                            n_match = {30'd0, r_hdr[3:0]} + 34'd4;
                            v_litext = (r_hdr[6:4] == 3'd7);
                        end
                    end
                    PH_DIST: begin
                        n_dist = {1'b0, i_byte} + 9'd1;
                        v_counts = 1'b1;
                        n_lit = {31'd0, r_hdr[6:4]};
                        n_match = {30'd0, r_hdr[3:0]} + 34'd4;
                        v_litext = (r_hdr[6:4] == 3'd7);
                    end
                    PH_LIT_TAG, PH_SEQ_TAG: begin
                        n_sh = 2'd0;
                        if (i_byte < 8'd253) begin
                            n_acc = {25'd0, i_byte};
                            v_extfin = 1'b1;
                        end else begin
                            if (i_byte == 8'd253) begin
                                n_acc = 33'd253;
                                n_left = 3'd1;
                            end else if (i_byte == 8'd254) begin
                                n_acc = 33'd509;
                                n_left = 3'd2;
                            end else begin
                                n_acc = 33'd65789;
                                n_left = 3'd4;
                            end
                            n_phase = v_forlit ? PH_LIT_DATA : PH_SEQ_DATA;
                        end
                    end
                    PH_LIT_DATA, PH_SEQ_DATA: begin
                        n_acc = r_acc + ({25'd0, i_byte} << {r_sh, 3'b000});
                        n_sh = r_sh + 1'b1;
                        n_left = r_left - 1'b1;
                        v_extfin = (r_left == 3'd1);
                    end
                    PH_LITERALS: begin
                        v_put = 1'b1;
                        v_pb = i_byte;
                        n_lit = r_lit - 1'b1;
                        v_start = (r_lit == 34'd1);
                    end
                    default: begin
                    end
                endcase
            end
        end

        // output byte: history, hash and table update
        if (v_put) begin
            v_bm = {24'd0, v_pb} * lzhd_pkg::HASH_MUL;
            v_full = {r_hprod[23:0], 8'h00} + v_bm;
            n_hprod = v_full;
            v_key = v_full[31:32-lzhd_pkg::HASH_BITS];
            n_pos = r_pos + 1'b1;
            o_res.out_valid = 1'b1;
            o_res.out_byte = v_pb;
        end

        if (v_counts) begin
            if (v_litext) begin
                n_phase = PH_LIT_TAG;
            end else if (!(n_hdr[7] && n_href == 16'hffff) && n_hdr[3:0] == 4'hf) begin
                n_phase = PH_SEQ_TAG;
            end else begin
                v_fin = 1'b1;
            end
        end

        if (v_extfin) begin
            if (v_forlit) begin
                n_lit = n_lit + {1'b0, n_acc};
                if (!(n_hdr[7] && n_href == 16'hffff) && n_hdr[3:0] == 4'hf) begin
                    n_phase = PH_SEQ_TAG;
                end else begin
                    v_fin = 1'b1;
                end
            end else begin
                n_match = n_match + {1'b0, n_acc};
                v_fin = 1'b1;
            end
        end

        if (v_fin) begin
            v_sum = {18'd0, r_pos} + {1'b0, n_lit} + {1'b0, n_match};
            if (v_sum > {18'd0, i_capacity}) begin
                n_err = lzhd_pkg::ERR_OVERFLOW;
                n_phase = PH_HALT;
            end else if (n_lit != '0) begin
                n_phase = PH_LITERALS;
            end else begin
                v_start = 1'b1;
            end
        end

        if (v_start) begin
            if (n_match == '0) begin
                n_phase = PH_HDR;
            end else if (n_hdr[7]) begin
                // an entry written by this very beat wins over the registered read
                v_tv = (v_put && v_key == n_href) ? r_pos[15:0] : i_tab_q;
                v_hsrc = {2'b00, v_tv} - 18'd3;
                if (v_tv < 16'd3 || v_hsrc[PW-1:0] >= n_pos) begin
                    n_err = lzhd_pkg::ERR_BADREF;
                    n_phase = PH_HALT;
                end else begin
                    n_src = v_hsrc[PW-1:0];
                    n_phase = PH_MATCH;
                end
            end else begin
                if ({8'd0, n_dist} > n_pos || n_dist == 9'd0) begin
                    n_err = lzhd_pkg::ERR_BADREF;
                    n_phase = PH_HALT;
                end else begin
                    n_src = n_pos - {8'd0, n_dist};
                    n_phase = PH_MATCH;
                end
            end
        end

        if (v_byte_step) begin
            if (i_last && n_err == lzhd_pkg::ERR_NONE) begin
                if (n_phase == PH_MATCH) begin
                    n_endp = 1'b1;
                end else if (n_phase != PH_HDR) begin
                    n_err = lzhd_pkg::ERR_TRUNC;
                    n_phase = PH_HALT;
                end
            end
            o_res.error_code = n_err;
            if (i_last && n_phase != PH_MATCH) begin
                o_res.out_last = 1'b1;
                v_end = 1'b1;
            end
        end

        o_res.produced_count = n_pos;

        if (v_end) begin
            n_phase = PH_HDR; n_hdr = '0; n_acc = '0; n_lit = '0; n_match = '0;
            n_href = '0; n_dist = '0; n_src = '0; n_err = '0; n_pos = '0;
            n_hprod = '0; n_left = '0; n_sh = '0; n_endp = 1'b0;
        end
        o_res.busy_res = (n_phase == PH_MATCH);
    end

    assign o_hist_we    = v_put;
    assign o_hist_waddr = r_pos[HIST_BITS-1:0];
    assign o_hist_wdata = v_pb;
    assign o_hist_raddr = n_src[HIST_BITS-1:0];
    assign o_tab_we     = v_put;
    assign o_tab_waddr  = v_key;
    assign o_tab_wdata  = r_pos[15:0];
    // keep reading the full index while the second index byte waits
    assign o_tab_raddr  = (r_phase == PH_HASH_HI) ? {i_byte, r_href[7:0]} : n_href;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR; r_hdr <= '0; r_acc <= '0; r_lit <= '0;
            r_match <= '0; r_href <= '0; r_dist <= '0; r_src <= '0;
            r_err <= '0; r_pos <= '0; r_hprod <= '0; r_left <= '0;
            r_sh <= '0; r_endp <= 1'b0; r_wait <= 1'b0;
        end else begin
            r_phase <= n_phase; r_hdr <= n_hdr; r_acc <= n_acc; r_lit <= n_lit;
            r_match <= n_match; r_href <= n_href; r_dist <= n_dist; r_src <= n_src;
            r_err <= n_err; r_pos <= n_pos; r_hprod <= n_hprod; r_left <= n_left;
            r_sh <= n_sh; r_endp <= n_endp;
            if (w_go) begin
                r_wait <= 1'b0;
            end else if (i_valid && i_room && w_hold) begin
                r_wait <= 1'b1;
            end
        end
    end
endmodule

/* rtl/core/lz_hash_block_decompressor.sv */
// LZ77-style block decompressor with hashed and short-distance references.
// One compressed byte or one match tick is taken per cycle while the output
// has room (tuser 0 = byte, 1 = tick), and gives at most one result. A hashed
// token whose match begins right after its two index bytes holds the second
// index byte back for the position table read. After reset the 2^16-entry
// position table is cleared, one entry a cycle, before input is taken;
// configuration writes are accepted throughout. History depth is 2^HIST_BITS.
// Depends on lzhd_pkg, lzhd_parser, lzhd_tab, lzhd_ram and the assert header.
`include "lz_hash_block_decompressor_assert.svh"

module lz_hash_block_decompressor #(
    parameter int HIST_BITS = lzhd_pkg::HIST_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] opcode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [8] busy_res, [11:9] error_code,
                                   // [28:12] produced_count, rest zero
    output logic        m_tuser,   // [0] out_valid
    output logic        m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);
    logic [lzhd_pkg::CAP_W-1:0]     r_capacity;
    logic                           r_m_valid;
    lzhd_pkg::t_result              r_m_res;
    logic                           w_room, w_tab_ready, w_wait;
    logic                           w_res_valid;
    lzhd_pkg::t_result              w_res;
    logic                           w_hist_we, w_tab_we;
    logic [HIST_BITS-1:0]           w_hist_waddr, w_hist_raddr;
    logic [7:0]                     w_hist_wdata, w_hist_q;
    logic [lzhd_pkg::HASH_BITS-1:0] w_tab_waddr, w_tab_raddr;
    logic [15:0]                    w_tab_wdata, w_tab_q;

    assign o_cfg_ready = 1'b1;
    assign w_room = w_tab_ready && (!r_m_valid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lzhd_pkg::CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    lzhd_parser #(.HIST_BITS(HIST_BITS)) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .i_room      (w_room),
        .o_ready     (s_tready),
        .i_op        (s_tuser),
        .i_byte      (s_tdata),
        .i_last      (s_tlast),
        .i_capacity  (r_capacity),
        .i_hist_q    (w_hist_q),
        .i_tab_q     (w_tab_q),
        .o_hist_we   (w_hist_we),
        .o_hist_waddr(w_hist_waddr),
        .o_hist_wdata(w_hist_wdata),
        .o_hist_raddr(w_hist_raddr),
        .o_tab_we    (w_tab_we),
        .o_tab_waddr (w_tab_waddr),
        .o_tab_wdata (w_tab_wdata),
        .o_tab_raddr (w_tab_raddr),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_wait      (w_wait)
    );

    lzhd_ram #(.AW(HIST_BITS), .DW(8)) u_hist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (w_hist_we),
        .i_waddr(w_hist_waddr),
        .i_wdata(w_hist_wdata),
        .i_raddr(w_hist_raddr),
        .o_rdata(w_hist_q)
    );

    lzhd_tab u_tab (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (w_tab_we),
        .i_waddr(w_tab_waddr),
        .i_wdata(w_tab_wdata),
        .i_raddr(w_tab_raddr),
        .o_rdata(w_tab_q),
        .o_ready(w_tab_ready)
    );

    // output register: loads a new result when it is empty or the old one leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {3'b000, r_m_res.produced_count, r_m_res.error_code,
                       r_m_res.busy_res, r_m_res.out_byte};
    assign m_tuser  = r_m_res.out_valid;
    assign m_tlast  = r_m_res.out_last;

    `LZHD_ASSERT_IMP(a_last_not_busy, i_clk, i_rst_n, m_tvalid && m_tlast, !m_tdata[8], "block ended with match bytes pending")
    `LZHD_ASSERT_IMP(a_busy_code, i_clk, i_rst_n, m_tvalid && (m_tdata[11:9] == lzhd_pkg::ERR_BUSY), m_tdata[8] && !m_tuser, "busy error beat carries a byte or no busy flag")
    `LZHD_ASSERT_IMP(a_wait_takes, i_clk, i_rst_n, w_wait && s_tvalid && w_room, s_tready, "table read done but beat not taken")
    `LZHD_ASSERT_NXT(a_clear_blocks, i_clk, i_rst_n, !w_tab_ready, !$past(s_tready) || w_tab_ready, "input taken during table clear")
endmodule

/* dv/lz_hash_block_decompressor_checker.sv */
`timescale 1ns / 1ps
// Checker for lz_hash_block_decompressor: watches the input, output and config
// channels, predicts every result and compares it. Depends on lzhd_pkg.
module lz_hash_block_decompressor_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    typedef enum logic [3:0] {
        PH_HDR, PH_HASH_LO, PH_HASH_HI, PH_DIST, PH_LIT_TAG, PH_LIT_DATA,
        PH_SEQ_TAG, PH_SEQ_DATA, PH_LITERALS, PH_MATCH, PH_HALT
    } t_parse_phase;

    logic [7:0]                 history [0:65535];
    logic [15:0]                pos_table [0:65535];
    logic [31:0]                tail4;
    logic [lzhd_pkg::POS_W-1:0] out_pos;
    t_parse_phase               phase;
    logic [7:0]                 hdr;
    longint                     ext_acc;
    longint                     lits_left;
    longint                     copy_left;
    logic [15:0]                hash_idx;
    int                         distance;
    logic [lzhd_pkg::POS_W-1:0] copy_src;
    logic [2:0]                 err_latch;
    logic [lzhd_pkg::CAP_W-1:0] capacity;
    int                         ext_left;
    int                         ext_shift;
    bit                         end_pending;

    lzhd_pkg::t_result expected_bytes [$];

    function automatic void clear_block();
        out_pos = '0;
        tail4 = '0;
        phase = PH_HDR;
        hdr = '0;
        ext_acc = 0;
        lits_left = 0;
        copy_left = 0;
        hash_idx = '0;
        distance = 0;
        copy_src = '0;
        err_latch = lzhd_pkg::ERR_NONE;
        ext_left = 0;
        ext_shift = 0;
        end_pending = 0;
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        logic [31:0] prod;
        history[out_pos[15:0]] = b;
        tail4 = {tail4[23:0], b};
        prod = tail4 * lzhd_pkg::HASH_MUL;
        pos_table[prod[31:16]] = out_pos[15:0];
        out_pos = out_pos + 1'b1;
    endfunction

    function automatic void halt(logic [2:0] code);
        err_latch = code;
        phase = PH_HALT;
    endfunction

    function automatic bit lit_only();
        return hdr[7] && hash_idx == 16'hffff;
    endfunction

    function automatic bit copy_ext_needed();
        return !lit_only() && hdr[3:0] == 4'hf;
    endfunction

    function automatic void begin_copy();
        int s;
        if (copy_left == 0) begin
            phase = PH_HDR;
            return;
        end
        if (hdr[7]) s = int'(pos_table[hash_idx]) - 3;
        else s = int'(out_pos) - distance;
        if (s < 0 || s >= int'(out_pos)) begin
            halt(lzhd_pkg::ERR_BADREF);
            return;
        end
        copy_src = s[lzhd_pkg::POS_W-1:0];
        phase = PH_MATCH;
    endfunction

    function automatic void header_done();
        if (longint'(out_pos) + lits_left + copy_left > longint'(capacity)) begin
            halt(lzhd_pkg::ERR_OVERFLOW);
            return;
        end
        if (lits_left > 0) phase = PH_LITERALS;
        else begin_copy();
    endfunction

    function automatic void counts_done(bit lit_ext);
        if (lit_ext) phase = PH_LIT_TAG;
        else if (copy_ext_needed()) phase = PH_SEQ_TAG;
        else header_done();
    endfunction

    function automatic void ext_finished(bit for_lit);
        if (for_lit) begin
            lits_left += ext_acc;
            if (copy_ext_needed()) phase = PH_SEQ_TAG;
            else header_done();
        end else begin
            copy_left += ext_acc;
            header_done();
        end
    endfunction

    function automatic void ext_tag(logic [7:0] b, bit for_lit);
        ext_shift = 0;
        if (b < 8'd253) begin
            ext_acc = b;
            ext_finished(for_lit);
            return;
        end
        if (b == 8'd253) begin
            ext_acc = 253;
            ext_left = 1;
        end else if (b == 8'd254) begin
            ext_acc = 509;
            ext_left = 2;
        end else begin
            ext_acc = 65789;
            ext_left = 4;
        end
        phase = for_lit ? PH_LIT_DATA : PH_SEQ_DATA;
    endfunction

    function automatic void ext_byte(logic [7:0] b, bit for_lit);
        ext_acc += longint'(b) << (ext_shift & 31);
        ext_shift += 8;
        if (ext_left > 0) ext_left--;
        if (ext_left == 0) ext_finished(for_lit);
    endfunction

    // Returns 1 when the beat yields a result.
    function automatic bit decode_beat(bit tick, logic [7:0] b, bit last,
                                       output lzhd_pkg::t_result r);
        r = '0;
        if (tick) begin
            if (phase != PH_MATCH) return 0;
            r.out_byte = history[copy_src[15:0]];
            copy_src = copy_src + 1'b1;
            emit_byte(r.out_byte);
            r.out_valid = 1'b1;
            copy_left--;
            if (copy_left == 0) phase = PH_HDR;
            r.produced_count = out_pos;
            if (copy_left == 0 && end_pending) begin
                r.out_last = 1'b1;
                clear_block();
            end
        end else if (phase == PH_MATCH) begin
            r.error_code = lzhd_pkg::ERR_BUSY;
            r.produced_count = out_pos;
        end else if (phase == PH_HALT) begin
            r.error_code = err_latch;
            r.produced_count = out_pos;
            if (last) begin
                r.out_last = 1'b1;
                clear_block();
            end
        end else begin
            case (phase)
                PH_HDR: begin
                    hdr = b;
                    phase = b[7] ? PH_HASH_LO : PH_DIST;
                end
                PH_HASH_LO: begin
                    hash_idx = {8'h00, b};
                    phase = PH_HASH_HI;
                end
                PH_HASH_HI: begin
                    hash_idx[15:8] = b;
                    if (hash_idx == 16'hffff) begin
                        lits_left = hdr - 128;
                        copy_left = 0;
                        counts_done(lits_left == 127);
                    end else begin
                        lits_left = hdr[6:4];
                        copy_left = hdr[3:0] + 4;
                        counts_done(lits_left == 7);
                    end
                end
                PH_DIST: begin
                    distance = b + 1;
                    lits_left = hdr[6:4];
                    copy_left = hdr[3:0] + 4;
                    counts_done(lits_left == 7);
                end
                PH_LIT_TAG:  ext_tag(b, 1'b1);
                PH_LIT_DATA: ext_byte(b, 1'b1);
                PH_SEQ_TAG:  ext_tag(b, 1'b0);
                PH_SEQ_DATA: ext_byte(b, 1'b0);
                default: begin
                    emit_byte(b);
                    r.out_byte = b;
                    r.out_valid = 1'b1;
                    lits_left--;
                    if (lits_left == 0) begin_copy();
                end
            endcase
            if (last && err_latch == lzhd_pkg::ERR_NONE) begin
                if (phase == PH_MATCH) end_pending = 1;
                else if (phase != PH_HDR) halt(lzhd_pkg::ERR_TRUNC);
            end
            r.error_code = err_latch;
            r.produced_count = out_pos;
            if (last && phase != PH_MATCH) begin
                r.out_last = 1'b1;
                clear_block();
            end
        end
        r.busy_res = (phase == PH_MATCH);
        return 1;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        capacity = lzhd_pkg::CAP_RESET;
        clear_block();
        for (int i = 0; i < 65536; i++) pos_table[i] = '0;
    end

    always @(posedge i_clk) begin
        lzhd_pkg::t_result r;
        lzhd_pkg::t_result exp_r;
        if (!i_rst_n) begin
            capacity = lzhd_pkg::CAP_RESET;
            clear_block();
            expected_bytes.delete();
        end else begin
            // a header taken at this edge still sees the old capacity
            if (s_tvalid && s_tready && decode_beat(s_tuser, s_tdata, s_tlast, r))
                expected_bytes.push_back(r);
            if (i_cfg_valid && o_cfg_ready) capacity = i_cfg_data;
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result, actual tdata=%h tuser=%b tlast=%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    o_fail_count++;
                end else begin
                    exp_r = expected_bytes.pop_front();
                    if (m_tdata !== {3'b000, exp_r.produced_count, exp_r.error_code,
                                     exp_r.busy_res, exp_r.out_byte}
                        || m_tuser !== exp_r.out_valid || m_tlast !== exp_r.out_last) begin
                        $display("%0t: mismatch, expected byte=%h valid=%b last=%b busy=%b err=%0d cnt=%0d",
                                 $time, exp_r.out_byte, exp_r.out_valid, exp_r.out_last,
                                 exp_r.busy_res, exp_r.error_code, exp_r.produced_count);
                        $display("%0t:   actual byte=%h valid=%b last=%b busy=%b err=%0d cnt=%0d",
                                 $time, m_tdata[7:0], m_tuser, m_tlast, m_tdata[8],
                                 m_tdata[11:9], m_tdata[28:12]);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_bytes.size();
    end
endmodule

/* dv/lz_hash_block_decompressor_test.sv */
`timescale 1ns / 1ps
// Top of the decompressor testbench: clock, reset, stimulus and verdict.
// Depends on lzhd_pkg, lz_hash_block_decompressor and its checker.
module lz_hash_block_decompressor_test;
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;
    localparam int   STALL_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;

    bit          steady;       // no idling on either side
    bit          hold_req;     // receiver long hold-off
    int          beats_sent;
    int          cap_now;
    int          idle_cycles;

    always #5 i_clk = ~i_clk;

    lz_hash_block_decompressor dut (.*);

    lz_hash_block_decompressor_checker checker_i (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold == 0) begin
                hold = 600;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || $urandom_range(99) >= 24;
            end
        end
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_beat(input logic op, input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        s_tlast <= last;
        beats_sent++;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            // a stray byte during a copy gets a busy error result and is otherwise ignored
            if ($urandom_range(99) < 3) send_beat(OP_BYTE, 8'($urandom_range(255)), 1'b0);
            send_beat(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_capacity(input int v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v[16:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_now = v;
    endtask

    // One block of random tokens; the final compressed byte carries tlast.
    task automatic send_block(input int ntok);
        logic [7:0] tok [$];
        int olen, lits, copies, kind, cut, dmax;
        olen = 0;
        for (int t = 0; t < ntok; t++) begin
            tok.delete();
            kind = $urandom_range(9);
            copies = 0;
            if (kind < 2) begin
                lits = $urandom_range(8);
                if ($urandom_range(19) == 0) lits = 127 + $urandom_range(20);
                tok.push_back(8'(128 + (lits >= 127 ? 127 : lits)));
                tok.push_back(8'hff);
                tok.push_back(8'hff);
                if (lits >= 127) tok.push_back(8'(lits - 127));
            end else begin
                lits = $urandom_range(7);
                copies = $urandom_range(19);
                tok.push_back({kind < 4, 3'(lits), 4'(copies < 15 ? copies : 15)});
                if (kind < 4) begin
                    tok.push_back(8'($urandom_range(255)));
                    tok.push_back(8'($urandom_range(254)));
                end else begin
                    dmax = olen + lits;
                    tok.push_back(8'((dmax > 0 && $urandom_range(19) != 0)
                                     ? $urandom_range((dmax > 256 ? 256 : dmax) - 1)
                                     : $urandom_range(255)));
                end
                if (lits == 7) begin
                    lits = 7 + $urandom_range(9);
                    tok.push_back(8'(lits - 7));
                end
                if (copies >= 15) begin
                    if (cap_now < 600 && $urandom_range(3) == 0) begin
                        tok.push_back(8'(253 + $urandom_range(2)));
                        repeat ($urandom_range(1, 4)) tok.push_back(8'($urandom_range(255)));
                    end else if ($urandom_range(29) == 0) begin
                        tok.push_back(8'd253);
                        tok.push_back(8'($urandom_range(20)));
                        copies = 253 + tok[$] + 19;
                    end else begin
                        tok.push_back(8'($urandom_range(12)));
                        copies = 19 + tok[$];
                    end
                end else begin
                    copies = copies + 4;
                end
            end
            for (int i = 0; i < lits; i++) tok.push_back(8'($urandom_range(255)));
            cut = tok.size();
            if (t == ntok - 1 && $urandom_range(9) == 0) cut = $urandom_range(1, tok.size());
            for (int i = 0; i < cut; i++)
                send_beat(OP_BYTE, tok[i], t == ntok - 1 && i == cut - 1);
            send_ticks(copies);
            if ($urandom_range(9) == 0) send_beat(OP_TICK, 8'($urandom_range(255)), 1'b0);
            olen += lits + copies;
        end
    endtask

    initial begin
        int phase_n;
        steady = 0;
        hold_req = 0;
        beats_sent = 0;
        cap_now = 65536;
        idle_cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle tick, literal-only token with extreme bytes
        send_beat(OP_TICK, 8'h00, 1'b0);
        send_beat(OP_BYTE, 8'h83, 1'b0);
        send_beat(OP_BYTE, 8'hff, 1'b0);
        send_beat(OP_BYTE, 8'hff, 1'b0);
        send_beat(OP_BYTE, 8'h00, 1'b0);
        send_beat(OP_BYTE, 8'hff, 1'b0);
        send_beat(OP_BYTE, 8'h5a, 1'b0);
        // overlapping copy at distance 1, end pending, byte while busy
        send_beat(OP_BYTE, 8'h00, 1'b0);
        send_beat(OP_BYTE, 8'h00, 1'b1);
        send_beat(OP_TICK, 8'hff, 1'b0);
        send_beat(OP_BYTE, 8'h11, 1'b0);
        send_beat(OP_TICK, 8'h00, 1'b1);
        send_beat(OP_TICK, 8'h00, 1'b0);
        send_beat(OP_TICK, 8'h00, 1'b0);
        // truncated header
        send_beat(OP_BYTE, 8'h90, 1'b1);
        // bad reference in an empty block, then end it while halted
        send_beat(OP_BYTE, 8'h01, 1'b0);
        send_beat(OP_BYTE, 8'h05, 1'b0);
        send_beat(OP_BYTE, 8'h77, 1'b1);
        drain();
        // zero capacity: overflow on the first header
        write_capacity(0);
        send_beat(OP_BYTE, 8'h81, 1'b0);
        send_beat(OP_BYTE, 8'hff, 1'b0);
        send_beat(OP_BYTE, 8'hff, 1'b0);
        send_beat(OP_BYTE, 8'h42, 1'b1);
        drain();

        phase_n = 0;
        while (beats_sent < 1320) begin
            case (phase_n % 5)
                0: write_capacity(65536);
                1: write_capacity(131071);
                2: write_capacity($urandom_range(300));
                3: write_capacity($urandom_range(65536));
                default: write_capacity($urandom_range(40, 2000));
            endcase
            steady = (phase_n == 2);
            if (phase_n == 3) hold_req = 1;
            repeat ($urandom_range(3, 8)) send_block($urandom_range(1, 6));
            drain();
            phase_n++;
        end
        steady = 0;
        drain();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
